FILE: design/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

    // Default store capacities.
    localparam int MAX_ROWS_DEF     = 32;
    localparam int MAX_COLS_DEF     = 32;
    localparam int MAX_KER_ROWS_DEF = 8;
    localparam int MAX_KER_COLS_DEF = 8;

    // Field widths of the stream payloads.
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 6;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int VALUE_W  = 40;
    localparam int STATUS_W = 2;

    // Register file.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;
    localparam int MSIZE_W    = 6;
    localparam int KSIZE_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KER_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KER_COLS = 3'd4;

    localparam logic [MODE_W-1:0]  MODE_RST     = 2'd0;
    localparam logic [MSIZE_W-1:0] MAT_ROWS_RST = 6'd32;
    localparam logic [MSIZE_W-1:0] MAT_COLS_RST = 6'd32;
    localparam logic [KSIZE_W-1:0] KER_ROWS_RST = 4'd3;
    localparam logic [KSIZE_W-1:0] KER_COLS_RST = 4'd3;

    // Convolution modes.
    localparam logic [MODE_W-1:0] MODE_FULL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAME  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VALID = 2'd2;

    // Function codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_LOAD_KER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_MAT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COORD = 2'd2;

    // Last drain count for the datapath pipeline behind the tap address: read, multiply, add.
    localparam logic DRAIN_LAST = 1'b1;

    typedef struct packed {
        logic load_ker;
        logic load_mat;
        logic capture;
        logic check;
        logic step;
        logic out_load;
    } c2d_cmd_t;

    typedef struct packed {
        logic err;
        logic last_tap;
        logic out_free;
    } c2d_sts_t;

endpackage

`default_nettype wire

FILE: design/conv2d_full_same_valid.sv
`default_nettype none

// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/tready   tuser: func; tdata: row, col, sample
// m_*       out        m_tvalid/tready   tuser: status; tdata: conv_value
// cfg_*     in         cfg_we            cfg_index selects register, cfg_data
//
// Load beats: the sample is written to its store at the accept edge.
// A compute beat holds off the next beat while the single shared multiply-accumulate
// walks one kernel tap per cycle, after a check step and before the drain of the
// read/multiply pipeline and the output load; a request with an error status skips
// the taps and the drain.
// Reset (rst_n low, asynchronous) restores the registers to full mode, a 32x32
// matrix and a 3x3 kernel; the stores are not cleared and must be loaded first.
// A result waiting on m_tready does not stop load beats; a following compute beat
// holds in its finish state until the output register is free.
module conv2d_full_same_valid #(
    parameter int MAX_ROWS     = c2d_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = c2d_pkg::MAX_COLS_DEF,
    parameter int MAX_KER_ROWS = c2d_pkg::MAX_KER_ROWS_DEF,
    parameter int MAX_KER_COLS = c2d_pkg::MAX_KER_COLS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [c2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // row_index, col_index,
                                                             // sample_value, zero pad
    input  wire logic [c2d_pkg::FUNC_W-1:0]        s_tuser,  // func
    // Output stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [c2d_pkg::VALUE_W-1:0]            m_tdata,  // conv_value
    output logic [c2d_pkg::STATUS_W-1:0]           m_tuser   // status
);
    import c2d_pkg::*;

    c2d_cmd_t cmd;
    c2d_sts_t sts;

    logic [COORD_W-1:0]         in_row;
    logic [COORD_W-1:0]         in_col;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [VALUE_W-1:0]  out_value;

    // Unpack the input beat: row in the low bits, then column, then the sample.
    assign in_row    = s_tdata[COORD_W-1:0];
    assign in_col    = s_tdata[2*COORD_W-1:COORD_W];
    assign in_sample = s_tdata[2*COORD_W+SAMPLE_W-1:2*COORD_W];

    c2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    c2d_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_KER_ROWS (MAX_KER_ROWS),
        .MAX_KER_COLS (MAX_KER_COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_row     (in_row),
        .in_col     (in_col),
        .in_sample  (in_sample),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_status (m_tuser)
    );

    // The exact sum is carried unchanged as the 40-bit beat.
    assign m_tdata = out_value;

endmodule

`default_nettype wire

FILE: design/c2d_ctrl.sv
`default_nettype none

module c2d_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [c2d_pkg::FUNC_W-1:0]    in_func,
    output logic                               in_ready,
    input  wire c2d_pkg::c2d_sts_t             sts,
    output c2d_pkg::c2d_cmd_t                  cmd
);
    import c2d_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       drain_reg;
    logic       drain_next;

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_func)
                        FUNC_LOAD_KER: cmd.load_ker = 1'b1;
                        FUNC_LOAD_MAT: cmd.load_mat = 1'b1;
                        FUNC_COMPUTE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (sts.err)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.last_tap)
                    begin
                        state_next = S_DRAIN;
                        drain_next = 1'b0;
                    end
                end
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // Taps are never issued for a request that failed its checks.
    a_no_step_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.err)
        else $error("tap issued for a failed request");

    // The last tap always hands over to the pipeline drain.
    a_last_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.last_tap) |=> (state_reg == S_DRAIN))
        else $error("last tap not followed by drain");

endmodule

`default_nettype wire

FILE: design/c2d_datapath.sv
`default_nettype none

module c2d_datapath #(
    parameter int MAX_ROWS     = c2d_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = c2d_pkg::MAX_COLS_DEF,
    parameter int MAX_KER_ROWS = c2d_pkg::MAX_KER_ROWS_DEF,
    parameter int MAX_KER_COLS = c2d_pkg::MAX_KER_COLS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [c2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [c2d_pkg::COORD_W-1:0]       in_row,
    input  wire logic [c2d_pkg::COORD_W-1:0]       in_col,
    input  wire logic signed [c2d_pkg::SAMPLE_W-1:0] in_sample,
    input  wire c2d_pkg::c2d_cmd_t                 cmd,
    output c2d_pkg::c2d_sts_t                      sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic signed [c2d_pkg::VALUE_W-1:0]     out_value,
    output logic [c2d_pkg::STATUS_W-1:0]           out_status
);
    import c2d_pkg::*;

    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int KER_DEPTH = MAX_KER_ROWS * MAX_KER_COLS;
    localparam int MA = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int KA = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

    // Configuration registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [MSIZE_W-1:0] mat_rows_reg;
    logic [MSIZE_W-1:0] mat_cols_reg;
    logic [KSIZE_W-1:0] ker_rows_reg;
    logic [KSIZE_W-1:0] ker_cols_reg;

    // Request and walk state.
    logic [COORD_W-1:0]  oi_reg;
    logic [COORD_W-1:0]  oj_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [KSIZE_W-1:0]  off_r_reg;
    logic [KSIZE_W-1:0]  off_c_reg;
    logic [KSIZE_W-1:0]  k_reg;
    logic [KSIZE_W-1:0]  l_reg;

    // Pipeline.
    logic signed [SAMPLE_W-1:0] mat_rd_reg;
    logic signed [SAMPLE_W-1:0] ker_rd_reg;
    logic                       s1_ok_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [VALUE_W-1:0]  acc_reg;

    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    logic signed [SAMPLE_W-1:0] mat_mem [MAT_DEPTH];
    logic signed [SAMPLE_W-1:0] ker_mem [KER_DEPTH];

    // Check logic.
    logic [7:0]          r8, c8, kr8, kc8;
    logic [7:0]          out_r8, out_c8, off_r8, off_c8;
    logic                size_err;
    logic [STATUS_W-1:0] chk_status;

    // Tap logic.
    logic [COORD_W:0]   pr, pc, mr, mc;
    logic               row_ok, col_ok, tap_ok;
    logic [KSIZE_W-1:0] kr_m1, kc_m1, kk, kl;
    logic [MA-1:0]      mat_addr, ld_mat_addr;
    logic [KA-1:0]      ker_addr, ld_ker_addr;
    logic               mat_we, ker_we;

    always_comb
    begin
        r8  = {2'b00, mat_rows_reg};
        c8  = {2'b00, mat_cols_reg};
        kr8 = {4'b0000, ker_rows_reg};
        kc8 = {4'b0000, ker_cols_reg};
        size_err = (r8 == 8'd0) || (c8 == 8'd0) || (kr8 == 8'd0) || (kc8 == 8'd0)
                || (int'(r8) > MAX_ROWS) || (int'(c8) > MAX_COLS)
                || (int'(kr8) > MAX_KER_ROWS) || (int'(kc8) > MAX_KER_COLS);
        out_r8 = r8;
        out_c8 = c8;
        off_r8 = 8'd0;
        off_c8 = 8'd0;
        case (mode_reg)
            MODE_FULL:
            begin
                out_r8 = r8 + kr8 - 8'd1;
                out_c8 = c8 + kc8 - 8'd1;
                off_r8 = kr8 - 8'd1;
                off_c8 = kc8 - 8'd1;
            end
            MODE_SAME:
            begin
                off_r8 = (kr8 - 8'd1) - (kr8 >> 1);
                off_c8 = (kc8 - 8'd1) - (kc8 >> 1);
            end
            MODE_VALID:
            begin
                if ((kr8 > r8) || (kc8 > c8))
                begin
                    size_err = 1'b1;
                end
                out_r8 = r8 - kr8 + 8'd1;
                out_c8 = c8 - kc8 + 8'd1;
            end
            default: size_err = 1'b1;
        endcase
        if (size_err)
        begin
            chk_status = ST_SIZE;
        end
        else if (({2'b00, oi_reg} >= out_r8) || ({2'b00, oj_reg} >= out_c8))
        begin
            chk_status = ST_COORD;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    always_comb
    begin
        pr = {1'b0, oi_reg} + {3'b000, k_reg};
        pc = {1'b0, oj_reg} + {3'b000, l_reg};
        row_ok = (pr >= {3'b000, off_r_reg})
              && ((pr - {3'b000, off_r_reg}) < {1'b0, mat_rows_reg});
        col_ok = (pc >= {3'b000, off_c_reg})
              && ((pc - {3'b000, off_c_reg}) < {1'b0, mat_cols_reg});
        tap_ok = row_ok && col_ok;
        mr = pr - {3'b000, off_r_reg};
        mc = pc - {3'b000, off_c_reg};
        mat_addr = tap_ok ? MA'(int'(mr) * MAX_COLS + int'(mc)) : '0;
        kr_m1 = ker_rows_reg - 4'd1;
        kc_m1 = ker_cols_reg - 4'd1;
        kk = kr_m1 - k_reg;
        kl = kc_m1 - l_reg;
        ker_addr = KA'(int'(kk) * MAX_KER_COLS + int'(kl));
        ld_mat_addr = MA'(int'(in_row) * MAX_COLS + int'(in_col));
        ld_ker_addr = KA'(int'(in_row) * MAX_KER_COLS + int'(in_col));
        mat_we = cmd.load_mat && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
        ker_we = cmd.load_ker && (int'(in_row) < MAX_KER_ROWS)
              && (int'(in_col) < MAX_KER_COLS);
        sts.err      = (status_reg != ST_OK);
        sts.last_tap = (k_reg == kr_m1) && (l_reg == kc_m1);
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[ld_mat_addr] <= in_sample;
        end
        mat_rd_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ker_we)
        begin
            ker_mem[ld_ker_addr] <= in_sample;
        end
        ker_rd_reg <= ker_mem[ker_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RST;
            mat_rows_reg <= MAT_ROWS_RST;
            mat_cols_reg <= MAT_COLS_RST;
            ker_rows_reg <= KER_ROWS_RST;
            ker_cols_reg <= KER_COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                REG_MAT_ROWS: mat_rows_reg <= cfg_data[MSIZE_W-1:0];
                REG_MAT_COLS: mat_cols_reg <= cfg_data[MSIZE_W-1:0];
                REG_KER_ROWS: ker_rows_reg <= cfg_data[KSIZE_W-1:0];
                REG_KER_COLS: ker_cols_reg <= cfg_data[KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            oi_reg <= in_row;
            oj_reg <= in_col;
        end
        if (cmd.check)
        begin
            status_reg <= chk_status;
            off_r_reg  <= off_r8[KSIZE_W-1:0];
            off_c_reg  <= off_c8[KSIZE_W-1:0];
            k_reg      <= '0;
            l_reg      <= '0;
        end
        else if (cmd.step)
        begin
            if (l_reg == kc_m1)
            begin
                l_reg <= '0;
                k_reg <= k_reg + 4'd1;
            end
            else
            begin
                l_reg <= l_reg + 4'd1;
            end
        end
        prod_reg <= s1_ok_reg ? PROD_W'(mat_rd_reg * ker_rd_reg) : '0;
        if (cmd.check)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_reg + {{(VALUE_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= sts.err ? '0 : acc_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ok_reg <= cmd.step && tap_ok;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_value_reg == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire

FILE: test/conv2d_full_same_valid_tb.sv
module conv2d_full_same_valid_tb;

    import c2d_pkg::*;

    // Store capacities of the block as instantiated (package defaults).
    localparam int MAT_CAP_R = MAX_ROWS_DEF;
    localparam int MAT_CAP_C = MAX_COLS_DEF;
    localparam int KER_CAP_R = MAX_KER_ROWS_DEF;
    localparam int KER_CAP_C = MAX_KER_COLS_DEF;

    // Zero bits above row, column and sample in the input tdata.
    localparam int PAD_W = 32 - 2 * COORD_W - SAMPLE_W;

    // Codes that the package leaves unnamed but the stimulus must reach.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd5;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;

    // After the last result the block is given more time than a compute
    // beat with an 8x8 kernel takes, before any register write.
    localparam int SETTLE_CYCLES = 80;
    // Length of the long receiver hold-off used to fill the block.
    localparam int HOLD_CYCLES   = 400;
    // Watchdog: several times the slowest legal run of this test.
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } conv_result_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;  // row_index, col_index, sample_value, zero pad
    logic [FUNC_W-1:0]     s_tuser   = '0;  // func
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;         // conv_value
    logic [STATUS_W-1:0]   m_tuser;         // status

    // Testbench copy of the register file, starting at the reset values.
    logic [MODE_W-1:0]  mode_q     = MODE_RST;
    logic [MSIZE_W-1:0] mat_rows_q = MAT_ROWS_RST;
    logic [MSIZE_W-1:0] mat_cols_q = MAT_COLS_RST;
    logic [KSIZE_W-1:0] ker_rows_q = KER_ROWS_RST;
    logic [KSIZE_W-1:0] ker_cols_q = KER_COLS_RST;

    // Testbench copy of both stores. Every entry is written by the fill
    // test before any compute beat is sent, so no read of an unwritten
    // entry can ever be caused.
    logic signed [SAMPLE_W-1:0] mat_copy [0:MAT_CAP_R*MAT_CAP_C-1];
    logic signed [SAMPLE_W-1:0] ker_copy [0:KER_CAP_R*KER_CAP_C-1];

    // Results predicted for accepted compute beats, oldest first.
    conv_result_t pending_results [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // Sender burst control; only the main process touches these.
    bit tx_gaps_on = 1'b1;
    int burst_left = 0;

    // Receiver control. The main process changes rx_stalls_on and hold_requests
    // with nonblocking assignments at a clock edge; the ready process reads them there.
    logic        rx_stalls_on  = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned rx_run        = 0;

    conv2d_full_same_valid uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predicts one element of the convolution for the current register
    // copy and store copy. The kernel is flipped in both axes, and taps
    // that fall into the zero padding add nothing. Size errors win over
    // coordinate errors, and any error carries a zero value.
    function automatic conv_result_t conv_element(input int oi, input int oj);
        conv_result_t res;
        int rows;
        int cols;
        int kr;
        int kc;
        int out_r;
        int out_c;
        int off_r;
        int off_c;
        int mr;
        int mc;
        longint acc;
        rows = int'(mat_rows_q);
        cols = int'(mat_cols_q);
        kr = int'(ker_rows_q);
        kc = int'(ker_cols_q);
        res.value = '0;
        res.status = ST_SIZE;
        if (rows == 0 || cols == 0 || kr == 0 || kc == 0)
            return res;
        if (rows > MAT_CAP_R || cols > MAT_CAP_C || kr > KER_CAP_R || kc > KER_CAP_C)
            return res;
        case (mode_q)
            MODE_FULL:
            begin
                out_r = rows + kr - 1;
                out_c = cols + kc - 1;
                off_r = kr - 1;
                off_c = kc - 1;
            end
            MODE_SAME:
            begin
                out_r = rows;
                out_c = cols;
                off_r = (kr - 1) - kr / 2;
                off_c = (kc - 1) - kc / 2;
            end
            MODE_VALID:
            begin
                if (kr > rows || kc > cols)
                    return res;
                out_r = rows - kr + 1;
                out_c = cols - kc + 1;
                off_r = 0;
                off_c = 0;
            end
            default:
                return res;
        endcase
        if (oi >= out_r || oj >= out_c)
        begin
            res.status = ST_COORD;
            return res;
        end
        acc = 0;
        for (int k = 0; k < kr; k++)
        begin
            mr = oi + k - off_r;
            if (mr < 0 || mr >= rows)
                continue;
            for (int l = 0; l < kc; l++)
            begin
                mc = oj + l - off_c;
                if (mc < 0 || mc >= cols)
                    continue;
                acc += longint'(mat_copy[mr * MAT_CAP_C + mc])
                     * longint'(ker_copy[(kr - 1 - k) * KER_CAP_C + (kc - 1 - l)]);
            end
        end
        res.value = acc[VALUE_W-1:0];
        res.status = ST_OK;
        return res;
    endfunction

    // Offers one beat and waits for the accept edge, then updates the
    // store copy or queues the predicted result. Valid is left high so
    // that a burst runs on without a bubble; at the end of a burst the
    // sender drops valid for a random gap, now and then long enough to
    // cover a whole compute beat.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [SAMPLE_W-1:0] sample);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{PAD_W{1'b0}}, sample, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        case (func)
            FUNC_LOAD_KER:
                if (row < KER_CAP_R && col < KER_CAP_C)
                    ker_copy[row * KER_CAP_C + col] = sample;
            FUNC_LOAD_MAT:
                if (row < MAT_CAP_R && col < MAT_CAP_C)
                    mat_copy[row * MAT_CAP_C + col] = sample;
            FUNC_COMPUTE:
                pending_results.push_back(conv_element(int'(row), int'(col)));
            default:
                ;
        endcase
        if (tx_gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    // Stops sending and waits until every predicted result has been
    // checked, then lets the block settle so that it is surely idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and mirrors the write in the register copy.
    // Indexes past the last register have no effect.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:     mode_q     = data[MODE_W-1:0];
            REG_MAT_ROWS: mat_rows_q = data[MSIZE_W-1:0];
            REG_MAT_COLS: mat_cols_q = data[MSIZE_W-1:0];
            REG_KER_ROWS: ker_rows_q = data[KSIZE_W-1:0];
            REG_KER_COLS: ker_cols_q = data[KSIZE_W-1:0];
            default:      ;
        endcase
    endtask

    // Brings the block to idle and programs every register.
    task automatic set_shape(input int mode, input int rows, input int cols,
                             input int kr, input int kc);
        drain();
        write_reg(REG_MODE,     CFG_DATA_W'(mode));
        write_reg(REG_MAT_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_MAT_COLS, CFG_DATA_W'(cols));
        write_reg(REG_KER_ROWS, CFG_DATA_W'(kr));
        write_reg(REG_KER_COLS, CFG_DATA_W'(kc));
    endtask

    // Random beats for the current shape. About half are compute beats,
    // aimed mostly inside the result area of the mode so that real sums
    // come back; the rest reload samples and coefficients, with a little
    // noise: unused function codes and loads beyond the stores. Beats the
    // block ignores are not counted.
    task automatic random_traffic(input int n);
        int sent;
        int pick;
        int out_r;
        int out_c;
        int rows;
        int cols;
        int kr;
        int kc;
        logic [FUNC_W-1:0]   f;
        logic [COORD_W-1:0]  r;
        logic [COORD_W-1:0]  c;
        logic [SAMPLE_W-1:0] v;
        rows = int'(mat_rows_q);
        cols = int'(mat_cols_q);
        kr = int'(ker_rows_q);
        kc = int'(ker_cols_q);
        case (mode_q)
            MODE_FULL:
            begin
                out_r = rows + kr - 1;
                out_c = cols + kc - 1;
            end
            MODE_VALID:
            begin
                out_r = rows - kr + 1;
                out_c = cols - kc + 1;
            end
            default:
            begin
                out_r = rows;
                out_c = cols;
            end
        endcase
        out_r = (out_r < 1) ? 1 : (out_r > 64) ? 64 : out_r;
        out_c = (out_c < 1) ? 1 : (out_c > 64) ? 64 : out_c;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN)
                                            : SAMPLE_W'($urandom());
            if (pick < 50)
            begin
                f = FUNC_COMPUTE;
                r = COORD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, out_r - 1));
                c = COORD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, out_c - 1));
            end
            else if (pick < 75)
            begin
                f = FUNC_LOAD_MAT;
                r = COORD_W'($urandom_range(0, MAT_CAP_R - 1));
                c = COORD_W'($urandom_range(0, MAT_CAP_C - 1));
            end
            else if (pick < 93)
            begin
                f = FUNC_LOAD_KER;
                r = COORD_W'($urandom_range(0, KER_CAP_R - 1));
                c = COORD_W'($urandom_range(0, KER_CAP_C - 1));
            end
            else if (pick < 97)
            begin
                f = $urandom_range(0, 1) ? FUNC_LOAD_MAT : FUNC_LOAD_KER;
                r = COORD_W'($urandom_range(0, 63));
                c = COORD_W'($urandom_range(0, 63));
            end
            else
            begin
                f = FUNC_UNUSED;
                r = COORD_W'($urandom_range(0, 63));
                c = COORD_W'($urandom_range(0, 63));
            end
            send_item(f, r, c, v);
            if (f == FUNC_COMPUTE
                || (f == FUNC_LOAD_MAT && r < MAT_CAP_R && c < MAT_CAP_C)
                || (f == FUNC_LOAD_KER && r < KER_CAP_R && c < KER_CAP_C))
                sent++;
        end
    endtask

    // Writes every store entry once. The kernel is filled with the most
    // negative coefficient, the top left 8x8 block of the matrix with the
    // most negative sample and the block below it with the most positive
    // one, so that the extreme sums of both signs can be requested later.
    task automatic test_fill_stores();
        logic [SAMPLE_W-1:0] v;
        tx_gaps_on = 1'b0;
        for (int r = 0; r < MAT_CAP_R; r++)
        begin
            for (int c = 0; c < MAT_CAP_C; c++)
            begin
                if (c < KER_CAP_C && r < KER_CAP_R)
                    v = SAMPLE_MIN;
                else if (c < KER_CAP_C && r < 2 * KER_CAP_R)
                    v = SAMPLE_MAX;
                else
                    v = SAMPLE_W'($urandom());
                send_item(FUNC_LOAD_MAT, COORD_W'(r), COORD_W'(c), v);
            end
        end
        for (int r = 0; r < KER_CAP_R; r++)
            for (int c = 0; c < KER_CAP_C; c++)
                send_item(FUNC_LOAD_KER, COORD_W'(r), COORD_W'(c), SAMPLE_MIN);
        drain();
    endtask

    // Requests with the registers still at their reset values: full mode,
    // a 32x32 matrix and a 3x3 kernel. Neither side idles here.
    task automatic test_reset_values();
        rx_stalls_on <= 1'b0;
        tx_gaps_on = 1'b0;
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd17, 6'd5, 16'hFFFF);
        send_item(FUNC_COMPUTE, 6'd33, 6'd33, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd34, 6'd0, 16'h0000);
        drain();
        rx_stalls_on <= 1'b1;
        tx_gaps_on = 1'b1;
    endtask

    // Directed beats: the largest sums of both signs, the last position
    // and the first position past the end of each mode, ignored loads
    // beyond the stores and an unused function code.
    task automatic test_extremes();
        set_shape(MODE_VALID, 32, 32, 8, 8);
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd8, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd24, 6'd24, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd25, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd0, 6'd25, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd63, 6'd63, 16'h0000);
        send_item(FUNC_UNUSED, 6'd63, 6'd63, 16'hFFFF);
        // These loads fall outside the stores and must change nothing.
        send_item(FUNC_LOAD_KER, 6'd8, 6'd0, SAMPLE_MAX);
        send_item(FUNC_LOAD_KER, 6'd63, 6'd63, SAMPLE_MAX);
        send_item(FUNC_LOAD_MAT, 6'd32, 6'd0, SAMPLE_MAX);
        send_item(FUNC_LOAD_MAT, 6'd0, 6'd63, SAMPLE_MAX);
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_LOAD_KER, 6'd7, 6'd7, SAMPLE_MAX);
        send_item(FUNC_LOAD_KER, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        set_shape(MODE_FULL, 32, 32, 8, 8);
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd38, 6'd38, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd39, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd0, 6'd39, 16'h0000);
        set_shape(MODE_SAME, 32, 32, 8, 8);
        send_item(FUNC_COMPUTE, 6'd0, 6'd0, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd31, 6'd31, 16'h0000);
        send_item(FUNC_COMPUTE, 6'd32, 6'd5, 16'h0000);
    endtask

    // Shapes that must give the size status: empty matrix or kernel in
    // each axis, sizes above the capacities, the unused mode, and a valid
    // mode kernel larger than the matrix in either axis.
    task automatic test_size_errors();
        set_shape(MODE_FULL, 0, 32, 3, 3);
        random_traffic(3);
        set_shape(MODE_SAME, 32, 0, 3, 3);
        random_traffic(3);
        set_shape(MODE_VALID, 8, 8, 0, 3);
        random_traffic(3);
        set_shape(MODE_FULL, 8, 8, 3, 0);
        random_traffic(3);
        set_shape(MODE_FULL, 33, 8, 3, 3);
        random_traffic(3);
        set_shape(MODE_SAME, 8, 63, 3, 3);
        random_traffic(3);
        set_shape(MODE_VALID, 8, 8, 9, 3);
        random_traffic(3);
        set_shape(MODE_FULL, 8, 8, 3, 15);
        random_traffic(3);
        set_shape(MODE_UNUSED, 8, 8, 3, 3);
        random_traffic(3);
        set_shape(MODE_VALID, 3, 3, 4, 2);
        random_traffic(3);
        set_shape(MODE_VALID, 5, 2, 2, 3);
        random_traffic(3);
    endtask

    // Writes to indexes past the last register must leave the shape as
    // it was; the traffic after them would show any change.
    task automatic test_unknown_register();
        set_shape(MODE_FULL, 8, 8, 3, 3);
        for (int i = int'(REG_UNUSED_LO); i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
        random_traffic(10);
    endtask

    // A fixed list of corner shapes followed by random ones.
    task automatic test_random_shapes();
        set_shape(MODE_FULL, 32, 32, 8, 8);
        random_traffic(6);
        set_shape(MODE_SAME, 32, 32, 8, 8);
        random_traffic(6);
        rx_stalls_on <= 1'b0;
        set_shape(MODE_VALID, 32, 32, 8, 8);
        random_traffic(6);
        rx_stalls_on <= 1'b1;
        set_shape(MODE_FULL, 1, 1, 1, 1);
        random_traffic(6);
        set_shape(MODE_VALID, 8, 8, 8, 8);
        random_traffic(6);
        tx_gaps_on = 1'b0;
        set_shape(MODE_SAME, 5, 7, 4, 3);
        random_traffic(6);
        tx_gaps_on = 1'b1;
        set_shape(MODE_SAME, 6, 4, 2, 8);
        random_traffic(6);
        set_shape(MODE_VALID, 32, 1, 1, 1);
        random_traffic(6);
        for (int i = 0; i < 6; i++)
        begin
            set_shape($urandom_range(0, 2), $urandom_range(1, 32), $urandom_range(1, 32),
                      $urandom_range(1, 8), $urandom_range(1, 8));
            random_traffic(6);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats with no gaps. One result waits in the output
    // register, the next compute beat holds in its finish state, and the
    // input has to stall until the receiver returns.
    task automatic test_backpressure();
        set_shape(MODE_FULL, 16, 16, 8, 8);
        tx_gaps_on = 1'b0;
        hold_requests <= hold_requests + 1;
        random_traffic(30);
        drain();
        tx_gaps_on = 1'b1;
    endtask

    // Receiver ready. A hold-off request from the main process starts a
    // long stretch of low ready; otherwise ready follows random runs of
    // high and low, or stays high while stalls are switched off.
    always @(posedge clk)
    begin : ready_pattern
        logic next_ready;
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!rx_stalls_on)
            m_tready <= 1'b1;
        else if (rx_run != 0)
            rx_run <= rx_run - 1;
        else
        begin
            next_ready = ($urandom_range(0, 99) < 65);
            m_tready <= next_ready;
            rx_run   <= next_ready ? $urandom_range(1, 30) : $urandom_range(1, 12);
        end
    end

    // Result checker: every accepted result beat is compared with the
    // oldest prediction, field by field.
    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with none expected: conv_value %0d, status %0d",
                       $signed(m_tdata), m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("conv_value mismatch: expected %0d, actual %0d",
                           want.value, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores();
        test_reset_values();
        test_extremes();
        test_size_errors();
        test_unknown_register();
        test_random_shapes();
        test_backpressure();
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/c2d_pkg.sv
design/c2d_ctrl.sv
design/c2d_datapath.sv
design/conv2d_full_same_valid.sv
test/conv2d_full_same_valid_tb.sv
